// File: design/pshl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_pkg
// shared types, constants and helpers of the path hash table lookup core
// ----------------------------------------------------------------------------
package pshl_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int SLOT_W      = 10;
    localparam int WORD_W      = 32;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_REG_W = 11;

    localparam int S_DATA_W    = 120;
    localparam int M_DATA_W    = 112;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd1;

    // input kinds
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_CHAR = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_BSLSH = 8'h5C;
    localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;
    localparam logic [WORD_W-1:0] HASH_MUL   = 32'd101;

    // one command between the front and the back
    typedef struct packed {
        logic                is_load;
        logic [SLOT_W-1:0]   slot;
        logic [WORD_W-1:0]   hash;     // table hash, or search key
        logic [WORD_W-1:0]   offset;
        logic [WORD_W-1:0]   length;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // separator and case mapping, sign extended
    function automatic logic [WORD_W-1:0] mapped_byte(input logic [CHAR_W-1:0] raw);
        logic [CHAR_W-1:0] c;
        c = raw;
        if (raw == CHAR_SLASH || raw == CHAR_BSLSH)
            c = CHAR_DOT;
        else if (raw >= CHAR_UC_A && raw <= CHAR_UC_Z)
            c = raw + CASE_DIFF;
        return {{(WORD_W-CHAR_W){c[CHAR_W-1]}}, c};
    endfunction

endpackage

// File: design/path_hash_sorted_table_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_hash_sorted_table_lookup_core
// path name hashing with binary search of a sorted directory table
// ----------------------------------------------------------------------------
// Load words (tuser 0) write one directory entry; name words (tuser 1) carry
// one character each and are hashed at one character per cycle, the last one
// marked by tlast. Loads and finished name keys pass through a two-entry
// queue to the search back end, which owns the table memories and runs the
// lookups in order, so a load always lands after every search queued before
// it. A load is one table write. Each search probe issues a read of the
// single-port table, then compares the key with the registered data; a
// search starts on the whole range of entry_count entries and ends on a
// hit or once the range is empty, which reports a miss. Character
// words stall only while the queue is full, so a new name hashes while the
// previous one is searched. A result waits in the output register while the
// back end starts the next command. Configuration writes are meant for
// idle periods; writing hash_seed drops any name in progress.
// ----------------------------------------------------------------------------
module path_hash_sorted_table_lookup_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_we,
    input  logic [pshl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pshl_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input words
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entry_index[9:0], entry_hash[41:10], entry_offset[73:42],
    // entry_length[105:74], name_char[113:106], zero pad [119:114]
    input  logic [pshl_pkg::S_DATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic                               s_tuser,
    // name_last
    input  logic                               s_tlast,
    // result words
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // match_index[9:0], match_offset[41:10], match_length[73:42],
    // name_hash[105:74], zero pad [111:106]
    output logic [pshl_pkg::M_DATA_W-1:0]      m_tdata,
    // found[0]
    output logic                               m_tuser
);

    logic [pshl_pkg::WORD_W-1:0]      seed_reg;
    logic [pshl_pkg::COUNT_REG_W-1:0] count_reg;
    logic [pshl_pkg::CNT_W-1:0]       count_eff;
    logic                             seed_load;
    logic                             accept;

    pshl_pkg::push_t                  push;
    pshl_pkg::q_status_t              q_status;
    pshl_pkg::cmd_t                   head;
    logic                             pop;

    logic                             found;
    logic [pshl_pkg::SLOT_W-1:0]      match_index;
    logic [pshl_pkg::WORD_W-1:0]      match_offset, match_length, name_hash;

    // configuration registers
    assign seed_load = cfg_we && (cfg_index == pshl_pkg::REG_HASH_SEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pshl_pkg::REG_HASH_SEED:   seed_reg  <= cfg_data;
                pshl_pkg::REG_ENTRY_COUNT: count_reg <= cfg_data[pshl_pkg::COUNT_REG_W-1:0];
                default:                   ;
            endcase
        end
    end

    // counts past the table size search the whole table
    assign count_eff = (32'(count_reg) > pshl_pkg::TABLE_DEPTH)
                     ? pshl_pkg::CNT_W'(pshl_pkg::TABLE_DEPTH)
                     : pshl_pkg::CNT_W'(count_reg);

    // every word waits for room in the queue
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    pshl_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .seed_load    (seed_load),
        .seed         (seed_load ? cfg_data : seed_reg),
        .accept       (accept),
        .mode         (s_tuser),
        .entry_index  (s_tdata[9:0]),
        .entry_hash   (s_tdata[41:10]),
        .entry_offset (s_tdata[73:42]),
        .entry_length (s_tdata[105:74]),
        .name_char    (s_tdata[113:106]),
        .name_last    (s_tlast),
        .push         (push)
    );

    pshl_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (pop),
        .status (q_status),
        .head   (head)
    );

    pshl_search u_search
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .count      (count_eff),
        .q_status   (q_status),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_found  (found),
        .out_index  (match_index),
        .out_offset (match_offset),
        .out_length (match_length),
        .out_hash   (name_hash)
    );

    assign m_tuser = found;
    assign m_tdata = {6'd0, name_hash, match_length, match_offset, match_index};

endmodule

// File: design/pshl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_front
// accepts words, hashes name characters, queues loads and searches
// ----------------------------------------------------------------------------
module pshl_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          seed_load,
    input  logic [pshl_pkg::WORD_W-1:0]   seed,
    input  logic                          accept,
    input  logic                          mode,
    input  logic [pshl_pkg::SLOT_W-1:0]   entry_index,
    input  logic [pshl_pkg::WORD_W-1:0]   entry_hash,
    input  logic [pshl_pkg::WORD_W-1:0]   entry_offset,
    input  logic [pshl_pkg::WORD_W-1:0]   entry_length,
    input  logic [pshl_pkg::CHAR_W-1:0]   name_char,
    input  logic                          name_last,
    output pshl_pkg::push_t               push
);

    logic [pshl_pkg::WORD_W-1:0] run_hash_reg, run_hash_next;
    logic [pshl_pkg::WORD_W-1:0] dot_hash_reg, dot_hash_next;
    logic                        dot_seen_reg, dot_seen_next;
    logic                        is_dot;
    logic [pshl_pkg::WORD_W-1:0] key;

    assign is_dot = (name_char == pshl_pkg::CHAR_DOT);

    // a dot that is also the last character counts itself
    assign key = is_dot       ? run_hash_reg :
                 dot_seen_reg ? dot_hash_reg : seed;

    always_comb
    begin
        run_hash_next = run_hash_reg;
        dot_hash_next = dot_hash_reg;
        dot_seen_next = dot_seen_reg;
        if (seed_load)
        begin
            run_hash_next = seed;
            dot_seen_next = 1'b0;
        end
        else if (accept && mode == pshl_pkg::MODE_CHAR)
        begin
            if (is_dot)
            begin
                dot_hash_next = run_hash_reg;
                dot_seen_next = 1'b1;
            end
            run_hash_next = run_hash_reg * pshl_pkg::HASH_MUL
                          + pshl_pkg::mapped_byte(name_char);
            if (name_last)
            begin
                run_hash_next = seed;
                dot_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_hash_reg <= '0;
            dot_hash_reg <= '0;
            dot_seen_reg <= 1'b0;
        end
        else
        begin
            run_hash_reg <= run_hash_next;
            dot_hash_reg <= dot_hash_next;
            dot_seen_reg <= dot_seen_next;
        end
    end

    always_comb
    begin
        push.valid      = 1'b0;
        push.cmd.is_load = (mode == pshl_pkg::MODE_LOAD);
        push.cmd.slot   = entry_index;
        push.cmd.hash   = entry_hash;
        push.cmd.offset = entry_offset;
        push.cmd.length = entry_length;
        if (accept)
        begin
            if (mode == pshl_pkg::MODE_LOAD)
            begin
                // slots beyond the table are dropped
                push.valid = (32'(entry_index) < pshl_pkg::TABLE_DEPTH);
            end
            else
            begin
                push.valid    = name_last;
                push.cmd.hash = key;
            end
        end
    end

endmodule

// File: design/pshl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module pshl_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  pshl_pkg::push_t     push,
    input  logic                pop,
    output pshl_pkg::q_status_t status,
    output pshl_pkg::cmd_t      head
);

    pshl_pkg::cmd_t slots_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           do_push, do_pop;

    assign status.full  = (fill_reg == 2'd2);
    assign status.empty = (fill_reg == 2'd0);
    assign do_push      = push.valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push.cmd;
    end

endmodule

// File: design/pshl_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_search
// directory table memories, entry loads and binary search sequencer
// ----------------------------------------------------------------------------
module pshl_search
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [pshl_pkg::CNT_W-1:0]       count,
    input  pshl_pkg::q_status_t              q_status,
    input  pshl_pkg::cmd_t                   head,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_found,
    output logic [pshl_pkg::SLOT_W-1:0]      out_index,
    output logic [pshl_pkg::WORD_W-1:0]      out_offset,
    output logic [pshl_pkg::WORD_W-1:0]      out_length,
    output logic [pshl_pkg::WORD_W-1:0]      out_hash
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;

    logic [pshl_pkg::WORD_W-1:0] hash_mem   [pshl_pkg::TABLE_DEPTH];
    logic [pshl_pkg::WORD_W-1:0] offset_mem [pshl_pkg::TABLE_DEPTH];
    logic [pshl_pkg::WORD_W-1:0] length_mem [pshl_pkg::TABLE_DEPTH];

    logic [1:0]                  state_reg, state_next;
    logic [pshl_pkg::CNT_W-1:0]  lo_reg, lo_next;
    logic [pshl_pkg::CNT_W-1:0]  hi_reg, hi_next;
    logic [pshl_pkg::IDX_W-1:0]  mid_reg;
    logic [pshl_pkg::WORD_W-1:0] key_reg;
    logic [pshl_pkg::WORD_W-1:0] rd_hash_reg, rd_off_reg, rd_len_reg;
    logic                        valid_reg, valid_next;
    logic                        found_reg;
    logic [pshl_pkg::SLOT_W-1:0] index_reg;
    logic [pshl_pkg::WORD_W-1:0] offset_reg, length_reg, hash_reg;

    logic [pshl_pkg::CNT_W:0]    mid_sum;
    logic [pshl_pkg::IDX_W-1:0]  mid;
    logic                        out_free;
    logic                        wr_en, rd_en, start, emit_hit, emit_miss;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[pshl_pkg::IDX_W:1];
    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        pop        = 1'b0;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        start      = 1'b0;
        emit_hit   = 1'b0;
        emit_miss  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    if (head.is_load)
                        wr_en = 1'b1;
                    else
                    begin
                        start      = 1'b1;
                        lo_next    = '0;
                        hi_next    = count;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CMP;
                end
                else if (out_free)
                begin
                    emit_miss  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (key_reg < rd_hash_reg)
                begin
                    hi_next    = pshl_pkg::CNT_W'(mid_reg);
                    state_next = ST_PROBE;
                end
                else if (key_reg > rd_hash_reg)
                begin
                    lo_next    = pshl_pkg::CNT_W'(mid_reg) + 1'b1;
                    state_next = ST_PROBE;
                end
                else if (out_free)
                begin
                    emit_hit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
            valid_next = 1'b0;
        if (emit_hit || emit_miss)
            valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (start)
            key_reg <= head.hash;
        if (rd_en)
            mid_reg <= mid;
        if (emit_hit)
        begin
            found_reg  <= 1'b1;
            index_reg  <= pshl_pkg::SLOT_W'(mid_reg);
            offset_reg <= rd_off_reg;
            length_reg <= rd_len_reg;
            hash_reg   <= key_reg;
        end
        else if (emit_miss)
        begin
            found_reg  <= 1'b0;
            index_reg  <= '0;
            offset_reg <= '0;
            length_reg <= '0;
            hash_reg   <= key_reg;
        end
    end

    // table memories: one write or one read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hash_mem[pshl_pkg::IDX_W'(head.slot)]   <= head.hash;
            offset_mem[pshl_pkg::IDX_W'(head.slot)] <= head.offset;
            length_mem[pshl_pkg::IDX_W'(head.slot)] <= head.length;
        end
        if (rd_en)
        begin
            rd_hash_reg <= hash_mem[mid];
            rd_off_reg  <= offset_mem[mid];
            rd_len_reg  <= length_mem[mid];
        end
    end

    assign out_valid  = valid_reg;
    assign out_found  = found_reg;
    assign out_index  = index_reg;
    assign out_offset = offset_reg;
    assign out_length = length_reg;
    assign out_hash   = hash_reg;

endmodule

// File: design/pshl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pshl_checker
// port-level checks of the path hash table lookup core
// ----------------------------------------------------------------------------
module pshl_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pshl_pkg::M_DATA_W-1:0]   m_tdata,
    input logic                            m_tuser
);

    // result held while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // a miss reports zero index, offset and length
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[73:0] == 74'd0)
        else $error("miss carries a nonzero entry");

    // no result out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

endmodule

bind path_hash_sorted_table_lookup_core pshl_checker u_pshl_checker (.*);
